### design/tpsc_pkg.sv
`default_nettype none

package tpsc_pkg;

    localparam int COMMAND_BITS = 8;
    localparam int SAMPLE_BITS  = 12;
    localparam int POS_W        = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;

    localparam logic [COMMAND_BITS-1:0] CMD_X = 8'hD0;
    localparam logic [COMMAND_BITS-1:0] CMD_Y = 8'h90;

    localparam logic [POS_W-1:0] ARROW_Y_LO = 12'd2900;
    localparam logic [POS_W-1:0] ARROW_Y_HI = 12'd3500;
    localparam logic [POS_W-1:0] DISP_Y_LO  = 12'd1700;
    localparam logic [POS_W-1:0] DISP_Y_HI  = 12'd2300;
    localparam logic [POS_W-1:0] STEP_Y_LO  = 12'd700;
    localparam logic [POS_W-1:0] STEP_Y_HI  = 12'd1300;

    localparam logic [1:0] BTN_NONE    = 2'd0;
    localparam logic [1:0] BTN_ARROWS  = 2'd1;
    localparam logic [1:0] BTN_DISPLAY = 2'd2;
    localparam logic [1:0] BTN_STEPPER = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_X_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_X_HIGH  = 2'd3;

    localparam logic [7:0]       RST_HALF_PERIOD = 8'd20;
    localparam logic [7:0]       RST_GAP         = 8'd10;
    localparam logic [POS_W-1:0] RST_BTN_X_LOW   = 12'd3500;
    localparam logic [POS_W-1:0] RST_BTN_X_HIGH  = 12'd3700;

    typedef struct packed {
        logic start_req;
        logic miso;
    } t_in_item;

    typedef struct packed {
        logic             cs_n;
        logic             sclk;
        logic             mosi;
        logic             busy_res;
        logic             done_res;
        logic [POS_W-1:0] x_pos;
        logic [POS_W-1:0] y_pos;
        logic [1:0]       button;
    } t_out_item;

    typedef struct packed {
        logic [7:0]       half_period_ticks;
        logic [7:0]       gap_ticks;
        logic [POS_W-1:0] button_x_low;
        logic [POS_W-1:0] button_x_high;
    } t_cfg;

endpackage

`default_nettype wire

### design/touch_panel_spi_coordinate_reader.sv
// The result transaction of an accepted tick transaction is registered and appears in the cycle after it is accepted.
// Throughput: 1 tick per cycle while not stalled; the phase sequencer and button decode update in one pass.
// A new tick is taken while the result register drains, stalled only when it is full.
// Reset (synchronous, active low): sequencer idle, pins cs_n high / sclk low,
// coordinates cleared, registers back to their defaults, no result pending.
`default_nettype none

module touch_panel_spi_coordinate_reader #(
    parameter int SAMPLE_BITS = tpsc_pkg::SAMPLE_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire tpsc_pkg::t_in_item                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output tpsc_pkg::t_out_item                     o_out_data,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [tpsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tpsc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    tpsc_pkg::t_cfg                 r_cfg;
    logic                           r_out_valid;
    logic                           w_accept;
    logic [tpsc_pkg::POS_W-1:0]     w_next_x, w_next_y;
    logic [1:0]                     w_button;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= tpsc_pkg::RST_HALF_PERIOD;
            r_cfg.gap_ticks         <= tpsc_pkg::RST_GAP;
            r_cfg.button_x_low      <= tpsc_pkg::RST_BTN_X_LOW;
            r_cfg.button_x_high     <= tpsc_pkg::RST_BTN_X_HIGH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tpsc_pkg::CFG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_data[7:0];
                tpsc_pkg::CFG_GAP:         r_cfg.gap_ticks         <= i_cfg_data[7:0];
                tpsc_pkg::CFG_BTN_X_LOW:   r_cfg.button_x_low      <= i_cfg_data;
                tpsc_pkg::CFG_BTN_X_HIGH:  r_cfg.button_x_high     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    tpsc_seq #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .i_button (w_button),
        .o_next_x (w_next_x),
        .o_next_y (w_next_y),
        .o_result (o_out_data)
    );

    tpsc_btn u_btn (
        .i_x      (w_next_x),
        .i_y      (w_next_y),
        .i_cfg    (r_cfg),
        .o_button (w_button)
    );

    a_done_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |->
            o_out_data.cs_n && !o_out_data.sclk && !o_out_data.busy_res)
        else $error("done transaction with converter still selected");

    a_select_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.cs_n |-> o_out_data.busy_res)
        else $error("converter selected outside a reading");

    a_sclk_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.sclk |-> !o_out_data.cs_n)
        else $error("serial clock high while deselected");

    a_y_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept ##1 (o_out_data.y_pos != $past(o_out_data.y_pos)) |->
            o_out_data.done_res)
        else $error("Y coordinate changed outside a done transaction");

endmodule

`default_nettype wire

### design/tpsc_btn.sv
`default_nettype none

module tpsc_btn (
    input  wire logic [tpsc_pkg::POS_W-1:0] i_x,
    input  wire logic [tpsc_pkg::POS_W-1:0] i_y,
    input  wire tpsc_pkg::t_cfg             i_cfg,
    output logic [1:0]                      o_button
);

    logic w_x_in;

    assign w_x_in = (i_x > i_cfg.button_x_low) && (i_x < i_cfg.button_x_high);

    always_comb begin
        o_button = tpsc_pkg::BTN_NONE;
        if (w_x_in) begin
            if (i_y > tpsc_pkg::ARROW_Y_LO && i_y < tpsc_pkg::ARROW_Y_HI) begin
                o_button = tpsc_pkg::BTN_ARROWS;
            end else if (i_y > tpsc_pkg::DISP_Y_LO && i_y < tpsc_pkg::DISP_Y_HI) begin
                o_button = tpsc_pkg::BTN_DISPLAY;
            end else if (i_y > tpsc_pkg::STEP_Y_LO && i_y < tpsc_pkg::STEP_Y_HI) begin
                o_button = tpsc_pkg::BTN_STEPPER;
            end
        end
    end

endmodule

`default_nettype wire

### design/tpsc_seq.sv
`default_nettype none

module tpsc_seq #(
    parameter int SAMPLE_BITS = tpsc_pkg::SAMPLE_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire tpsc_pkg::t_in_item           i_item,
    input  wire tpsc_pkg::t_cfg               i_cfg,
    input  wire logic [1:0]                   i_button,
    output logic [tpsc_pkg::POS_W-1:0]        o_next_x,
    output logic [tpsc_pkg::POS_W-1:0]        o_next_y,
    output tpsc_pkg::t_out_item               o_result
);

    localparam int CMD_B    = tpsc_pkg::COMMAND_BITS;
    localparam int POS_W    = tpsc_pkg::POS_W;
    localparam int MAX_BITS = (CMD_B > SAMPLE_BITS) ? CMD_B : SAMPLE_BITS;
    localparam int BIT_W    = $clog2(MAX_BITS);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD_HI,
        PH_CMD_LO,
        PH_GAP,
        PH_RD_HI,
        PH_RD_LO,
        PH_CS_UP
    } t_phase;

    t_phase                   r_phase, n_phase, w_phase;
    logic                     r_ybit, n_ybit, w_ybit;
    logic [BIT_W-1:0]         r_bit, n_bit, w_bit;
    logic [7:0]               r_dly, n_dly, w_dly;
    logic [CMD_B-1:0]         r_cmd, n_cmd, w_cmd;
    logic [SAMPLE_BITS-1:0]   r_sample, n_sample;
    logic [POS_W-1:0]         r_x, n_x, r_y, n_y;
    logic                     r_cs_n, n_cs_n, r_sclk, n_sclk, r_mosi, n_mosi;
    logic                     r_busy, n_busy, r_done, n_done;
    logic [1:0]               r_button;
    logic [POS_W-1:0]         w_sample_top;
    logic [7:0]               w_half;
    logic [8:0]               w_dsum;
    logic                     w_half_end;

    generate
        if (SAMPLE_BITS >= POS_W) begin : g_wide
            assign w_sample_top = r_sample[SAMPLE_BITS-1 -: POS_W];
        end else begin : g_narrow
            assign w_sample_top = {{(POS_W-SAMPLE_BITS){1'b0}}, r_sample};
        end
    endgenerate

    assign w_half     = (i_cfg.half_period_ticks == 8'd0) ? 8'd1 : i_cfg.half_period_ticks;
    assign w_dsum     = {1'b0, w_dly} + 9'd1;
    assign w_half_end = (w_dsum >= {1'b0, w_half});

    always_comb begin
        if (r_phase == PH_IDLE && i_item.start_req) begin
            w_phase = PH_CMD_HI;
            w_ybit  = 1'b0;
            w_bit   = '0;
            w_dly   = '0;
            w_cmd   = tpsc_pkg::CMD_X;
        end else begin
            w_phase = r_phase;
            w_ybit  = r_ybit;
            w_bit   = r_bit;
            w_dly   = r_dly;
            w_cmd   = r_cmd;
        end
    end

    always_comb begin
        n_phase  = w_phase;
        n_ybit   = w_ybit;
        n_bit    = w_bit;
        n_dly    = w_dly;
        n_cmd    = w_cmd;
        n_sample = r_sample;
        n_x      = r_x;
        n_y      = r_y;
        n_cs_n   = 1'b1;
        n_sclk   = 1'b0;
        n_mosi   = w_cmd[CMD_B-1];
        n_busy   = 1'b0;
        n_done   = 1'b0;
        unique case (w_phase)
            PH_CMD_HI, PH_RD_HI: begin
                n_cs_n = 1'b0;
                n_sclk = 1'b1;
                n_busy = 1'b1;
                if (w_half_end) begin
                    n_dly   = '0;
                    n_phase = (w_phase == PH_CMD_HI) ? PH_CMD_LO : PH_RD_LO;
                end else begin
                    n_dly = w_dsum[7:0];
                end
            end
            PH_CMD_LO: begin
                n_cs_n = 1'b0;
                n_busy = 1'b1;
                if (w_half_end) begin
                    n_dly = '0;
                    n_cmd = {w_cmd[CMD_B-2:0], 1'b0};
                    if (w_bit == BIT_W'(CMD_B - 1)) begin
                        n_bit   = '0;
                        n_phase = (i_cfg.gap_ticks != 8'd0) ? PH_GAP : PH_RD_HI;
                    end else begin
                        n_bit   = w_bit + BIT_W'(1);
                        n_phase = PH_CMD_HI;
                    end
                end else begin
                    n_dly = w_dsum[7:0];
                end
            end
            PH_GAP: begin
                n_cs_n = 1'b0;
                n_busy = 1'b1;
                if (w_dsum >= {1'b0, i_cfg.gap_ticks}) begin
                    n_dly   = '0;
                    n_phase = PH_RD_HI;
                end else begin
                    n_dly = w_dsum[7:0];
                end
            end
            PH_RD_LO: begin
                n_cs_n = 1'b0;
                n_busy = 1'b1;
                if (w_half_end) begin
                    n_dly    = '0;
                    n_sample = {r_sample[SAMPLE_BITS-2:0], i_item.miso};
                    if (w_bit == BIT_W'(SAMPLE_BITS - 1)) begin
                        n_bit   = '0;
                        n_phase = PH_CS_UP;
                    end else begin
                        n_bit   = w_bit + BIT_W'(1);
                        n_phase = PH_RD_HI;
                    end
                end else begin
                    n_dly = w_dsum[7:0];
                end
            end
            PH_CS_UP: begin
                n_mosi   = 1'b0;
                n_dly    = '0;
                n_bit    = '0;
                n_sample = '0;
                if (w_ybit) begin
                    n_y     = w_sample_top;
                    n_done  = 1'b1;
                    n_ybit  = 1'b0;
                    n_phase = PH_IDLE;
                end else begin
                    n_x     = w_sample_top;
                    n_busy  = 1'b1;
                    n_cmd   = tpsc_pkg::CMD_Y;
                    n_ybit  = 1'b1;
                    n_phase = PH_CMD_HI;
                end
            end
            default: begin
                n_mosi  = 1'b0;
                n_ybit  = 1'b0;
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_next_x = n_x;
    assign o_next_y = n_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_ybit   <= 1'b0;
            r_bit    <= '0;
            r_dly    <= '0;
            r_cmd    <= '0;
            r_sample <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_cs_n   <= 1'b1;
            r_sclk   <= 1'b0;
            r_mosi   <= 1'b0;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_button <= tpsc_pkg::BTN_NONE;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_ybit   <= n_ybit;
            r_bit    <= n_bit;
            r_dly    <= n_dly;
            r_cmd    <= n_cmd;
            r_sample <= n_sample;
            r_x      <= n_x;
            r_y      <= n_y;
            r_cs_n   <= n_cs_n;
            r_sclk   <= n_sclk;
            r_mosi   <= n_mosi;
            r_busy   <= n_busy;
            r_done   <= n_done;
            r_button <= i_button;
        end
    end

    always_comb begin
        o_result.cs_n     = r_cs_n;
        o_result.sclk     = r_sclk;
        o_result.mosi     = r_mosi;
        o_result.busy_res = r_busy;
        o_result.done_res = r_done;
        o_result.x_pos    = r_x;
        o_result.y_pos    = r_y;
        o_result.button   = r_button;
    end

endmodule

`default_nettype wire
